/* hw/rtl/shrr_pkg.sv */
// Package for the snapshot history ring: command codes, sequencer states,
// slot word layout and default ring depth. No dependencies.
`timescale 1ns / 1ps

package shrr_pkg;

	localparam int HIST_DEPTH = 64;
	localparam int CMD_W      = 2;
	localparam int STAMP_W    = 32;
	localparam int PAYLOAD_W  = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADVANCE = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_REWIND  = 2'd2
	} cmd_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_WALK  = 6'b000100,
		ST_RNEW  = 6'b001000,
		ST_ROLD  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic                 written;
		logic [STAMP_W-1:0]   stamp;
		logic [PAYLOAD_W-1:0] payload;
	} slot_t;

endpackage

/* hw/rtl/snapshot_history_ring_rewind.sv */
// Ring of time-stamped snapshots with advance, write-and-advance and rewind.
// Depends on shrr_pkg (command codes, states, slot layout).
`timescale 1ns / 1ps

// Channel   Handshake        Fields
// command   start / busy     cmd, stamp, payload
// result    done (strobe)    ok, newest_*, oldest_*
//
// One slot memory with a single read port sets the timing: one slot per cycle.
// Advance and write: after accept, ST_RNEW and ST_ROLD, then done in ST_FIN.
// Rewind: ST_WALK visits 1 to DEPTH slots, then ST_RNEW, ST_ROLD, done in ST_FIN.
// busy stays high from accept through the done cycle.
// After reset a clearing pass writes each slot in turn to reset the written
// marks; busy is high meanwhile. The receiver cannot stall: each result is
// shown for one cycle.

module snapshot_history_ring_rewind #(
	parameter int DEPTH = shrr_pkg::HIST_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [shrr_pkg::CMD_W-1:0]     cmd,
	input  logic [shrr_pkg::STAMP_W-1:0]   stamp,
	input  logic [shrr_pkg::PAYLOAD_W-1:0] payload,
	output logic                           done,
	output logic                           ok,
	output logic                           newest_valid,
	output logic [shrr_pkg::STAMP_W-1:0]   newest_stamp,
	output logic [shrr_pkg::PAYLOAD_W-1:0] newest_payload,
	output logic                           oldest_valid,
	output logic [shrr_pkg::STAMP_W-1:0]   oldest_stamp,
	output logic [shrr_pkg::PAYLOAD_W-1:0] oldest_payload
);
	import shrr_pkg::*;

	localparam int          PW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	state_t               state_q;
	logic [PW-1:0]        newest_q;
	logic [PW-1:0]        oldest_q;
	logic [PW-1:0]        p_q;
	logic [PW-1:0]        clr_q;
	logic [STAMP_W-1:0]   target_q;
	logic                 ok_q;
	slot_t                hold_q;
	slot_t                rd_data_q;
	slot_t                slot_mem [DEPTH];

	logic                 accept;
	logic [PW-1:0]        newest_inc;
	logic [PW-1:0]        oldest_inc;
	logic [PW-1:0]        p_dec;
	logic [PW-1:0]        p_inc;
	logic                 walk_hit;
	logic                 wr_en;
	logic [PW-1:0]        wr_addr;
	slot_t                wr_data;
	logic [PW-1:0]        rd_addr;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign newest_inc = wrap_inc(newest_q);
	assign oldest_inc = wrap_inc(oldest_q);
	assign p_dec      = wrap_dec(p_q);
	assign p_inc      = wrap_inc(p_q);
	// an unwritten slot ends the search just like an early enough stamp
	assign walk_hit   = !rd_data_q.written || (rd_data_q.stamp <= target_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = newest_inc;
		wr_data = '{written: 1'b1, stamp: stamp, payload: payload};
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (accept && (cmd_t'(cmd) == CMD_WRITE)) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_WALK: rd_addr = p_dec;
			ST_ROLD: rd_addr = oldest_q;
			default: rd_addr = newest_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= slot_mem[rd_addr];
		if (state_q == ST_ROLD) begin
			hold_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			newest_q <= '0;
			oldest_q <= '0;
			p_q      <= '0;
			clr_q    <= '0;
			target_q <= '0;
			ok_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == PTR_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RNEW;
						ok_q    <= 1'b1;
						unique case (cmd_t'(cmd))
							CMD_ADVANCE, CMD_WRITE: begin
								newest_q <= newest_inc;
								if (newest_inc == oldest_q) begin
									oldest_q <= oldest_inc;
								end
							end
							CMD_REWIND: begin
								p_q      <= newest_q;
								target_q <= stamp;
								state_q  <= ST_WALK;
							end
							default: begin
								ok_q <= 1'b0;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (walk_hit) begin
						newest_q <= p_q;
						oldest_q <= p_inc;
						ok_q     <= 1'b1;
						state_q  <= ST_RNEW;
					end else if (p_dec == newest_q) begin
						// wrapped all the way round: leave the pointers alone
						ok_q    <= 1'b0;
						state_q <= ST_RNEW;
					end else begin
						p_q <= p_dec;
					end
				end
				ST_RNEW: state_q <= ST_ROLD;
				ST_ROLD: state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done           = (state_q == ST_FIN);
	assign ok             = ok_q;
	assign newest_valid   = hold_q.written;
	assign newest_stamp   = hold_q.written ? hold_q.stamp : '0;
	assign newest_payload = hold_q.written ? hold_q.payload : '0;
	assign oldest_valid   = rd_data_q.written;
	assign oldest_stamp   = rd_data_q.written ? rd_data_q.stamp : '0;
	assign oldest_payload = rd_data_q.written ? rd_data_q.payload : '0;

`ifndef SYNTHESIS
	a_done_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_ROLD))
		else $error("result beat without preceding slot reads");

	a_rewind_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && walk_hit) |=> (oldest_q == $past(p_inc)))
		else $error("rewind did not place oldest after new newest");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == ST_CLEAR) |-> (clr_q == PTR_LAST))
		else $error("clearing pass left before covering every slot");
`endif

endmodule
